// File: hdl/two_operator_fm_voice_defines.svh
// Assertion macros for the two-operator FM voice.
// Included by the top level; uses the clk and rst_n names of the including module.
`ifndef TWO_OPERATOR_FM_VOICE_DEFINES_SVH
`define TWO_OPERATOR_FM_VOICE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TOFV_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tofv: same-cycle check failed");
`define TOFV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tofv: next-cycle check failed");
`else
`define TOFV_ASSERT_SAME(lbl, ante, cons)
`define TOFV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/tofv_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sine table generator of the FM voice.
// No dependencies.
package tofv_pkg;

    localparam int PHASE_BITS_DEFAULT     = 24;
    localparam int SINE_ADDR_BITS_DEFAULT = 10;
    localparam int SAMPLE_BITS_DEFAULT    = 16;

    localparam int          VOLUME_BITS      = 16;
    localparam int          VOLUME_FRAC_BITS = 15;
    localparam int unsigned VOLUME_UNITY     = 32768;
    localparam int unsigned MOD_DEPTH_RESET  = 38044;

    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CARRIER_STEP   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULATOR_STEP = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOD_DEPTH      = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLUME         = 2'd3;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic look;          // sine lookup, registered ROM read
        logic look_carrier;  // lookup at carrier phase, else modulator phase
        logic mul;           // load product register
        logic mul_volume;    // multiply by volume, else by modulation depth
        logic phase_update;  // advance both phases
        logic out_load;      // load output register
    } tofv_cmd_t;

    typedef struct packed {
        logic out_free;
    } tofv_status_t;

    // term * x^2 in Q30, two truncating steps
    function automatic longint unsigned taylor_power(longint unsigned term,
                                                     longint unsigned x);
        longint unsigned t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Quarter-wave entry: Taylor series of sin in Q30, scaled to full sample range.
    function automatic logic [63:0] sine_rom_entry(int unsigned index,
                                                   int unsigned addr_bits,
                                                   int unsigned sample_bits);
        longint unsigned x;
        longint unsigned term;
        longint unsigned sample_max;
        longint          sum;
        longint          v;
        x = (HALF_PI_Q30 * (64'(index) * 64'd2 + 64'd1)) >> (addr_bits + 1);
        term = x;
        sum = longint'(x);
        term = taylor_power(term, x) / 64'd6;
        sum = sum - longint'(term);
        term = taylor_power(term, x) / 64'd20;
        sum = sum + longint'(term);
        term = taylor_power(term, x) / 64'd42;
        sum = sum - longint'(term);
        term = taylor_power(term, x) / 64'd72;
        sum = sum + longint'(term);
        term = taylor_power(term, x) / 64'd110;
        sum = sum - longint'(term);
        term = taylor_power(term, x) / 64'd156;
        sum = sum + longint'(term);
        term = taylor_power(term, x) / 64'd210;
        sum = sum - longint'(term);
        term = taylor_power(term, x) / 64'd272;
        sum = sum + longint'(term);
        sample_max = (64'd1 << (sample_bits - 1)) - 64'd1;
        if (sum < 0)
            sum = 0;
        v = (sum * longint'(sample_max) + (longint'(1) <<< 29)) >>> 30;
        if (v > longint'(sample_max))
            v = longint'(sample_max);
        return $unsigned(v);
    endfunction

endpackage

// File: hdl/tofv_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine magnitude ROM with registered read.
// Depends on tofv_pkg for the table generator.
module tofv_sine_rom #(
    parameter int ADDR_BITS = tofv_pkg::SINE_ADDR_BITS_DEFAULT,
    parameter int DATA_BITS = tofv_pkg::SAMPLE_BITS_DEFAULT - 1
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] rom_mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        assign rom_mem[i] = DATA_BITS'(tofv_pkg::sine_rom_entry(i, ADDR_BITS, DATA_BITS + 1));
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= rom_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tofv_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the FM voice: takes requests and steps the datapath.
// Depends on tofv_pkg for the command and status structs.
module tofv_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   sample_request,
    output logic                   in_stall,
    output tofv_pkg::tofv_cmd_t    cmd,
    input  tofv_pkg::tofv_status_t status
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MOD_LOOK = 7'b0000010,
        S_MOD_MUL  = 7'b0000100,
        S_PHASE    = 7'b0001000,
        S_CAR_LOOK = 7'b0010000,
        S_CAR_MUL  = 7'b0100000,
        S_OUT      = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && sample_request)
                    state_next = S_MOD_LOOK;
            end
            S_MOD_LOOK:
            begin
                cmd.look = 1'b1;
                state_next = S_MOD_MUL;
            end
            S_MOD_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                cmd.phase_update = 1'b1;
                state_next = S_CAR_LOOK;
            end
            S_CAR_LOOK:
            begin
                cmd.look = 1'b1;
                cmd.look_carrier = 1'b1;
                state_next = S_CAR_MUL;
            end
            S_CAR_MUL:
            begin
                cmd.mul = 1'b1;
                cmd.mul_volume = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// File: hdl/tofv_datapath.sv
`timescale 1ns / 1ps
// Datapath of the FM voice: registers, phases, shared multiplier, output stage.
// Depends on tofv_pkg and tofv_sine_rom.
module tofv_datapath #(
    parameter int PHASE_BITS     = tofv_pkg::PHASE_BITS_DEFAULT,
    parameter int SINE_ADDR_BITS = tofv_pkg::SINE_ADDR_BITS_DEFAULT,
    parameter int SAMPLE_BITS    = tofv_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tofv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PHASE_BITS-1:0]               cfg_data,
    input  tofv_pkg::tofv_cmd_t                 cmd,
    output tofv_pkg::tofv_status_t              status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    localparam int MAG_BITS   = SAMPLE_BITS - 1;
    localparam int DEPTH_BITS = PHASE_BITS - 1;
    localparam int VOL_BITS   = tofv_pkg::VOLUME_BITS;
    localparam int FRAC_BITS  = tofv_pkg::VOLUME_FRAC_BITS;
    localparam int MUL_A_BITS = (DEPTH_BITS > VOL_BITS) ? DEPTH_BITS : VOL_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MAG_BITS;

    logic [PHASE_BITS-1:0] carrier_step_reg;
    logic [PHASE_BITS-1:0] modulator_step_reg;
    logic [DEPTH_BITS-1:0] mod_depth_reg;
    logic [VOL_BITS-1:0]   volume_reg;
    logic [VOL_BITS-1:0]   vol_in;

    logic [PHASE_BITS-1:0] carrier_phase_reg;
    logic [PHASE_BITS-1:0] carrier_phase_next;
    logic [PHASE_BITS-1:0] modulator_phase_reg;
    logic [PHASE_BITS-1:0] modulator_phase_next;

    logic [PHASE_BITS-1:0]     look_phase;
    logic [1:0]                look_quad;
    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic [MAG_BITS-1:0]       rom_data;
    logic                      neg_reg;

    logic [MUL_A_BITS-1:0] mul_a;
    logic [PROD_BITS-1:0]  product_reg;
    logic [PROD_BITS-1:0]  product_next;
    logic [PROD_BITS:0]    dev_sum;
    logic [PHASE_BITS-1:0] dev_mag;
    logic [PHASE_BITS-1:0] dev_add;
    logic [PROD_BITS:0]    vol_sum;
    logic [SAMPLE_BITS-1:0] out_mag;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic [SAMPLE_BITS-1:0] sample_out_next;

    // configuration
    assign vol_in = cfg_data[VOL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_step_reg   <= '0;
            modulator_step_reg <= '0;
            mod_depth_reg      <= DEPTH_BITS'(tofv_pkg::MOD_DEPTH_RESET);
            volume_reg         <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tofv_pkg::CFG_CARRIER_STEP:   carrier_step_reg   <= cfg_data;
                tofv_pkg::CFG_MODULATOR_STEP: modulator_step_reg <= cfg_data;
                tofv_pkg::CFG_MOD_DEPTH:      mod_depth_reg      <= cfg_data[DEPTH_BITS-1:0];
                tofv_pkg::CFG_VOLUME:
                begin
                    if (vol_in > VOL_BITS'(tofv_pkg::VOLUME_UNITY))
                        volume_reg <= VOL_BITS'(tofv_pkg::VOLUME_UNITY);
                    else
                        volume_reg <= vol_in;
                end
                default: ;
            endcase
        end
    end

    // sine lookup: quadrant bits mirror the address and set the sign
    assign look_phase = cmd.look_carrier ? carrier_phase_reg : modulator_phase_reg;
    assign look_quad  = look_phase[PHASE_BITS-1 -: 2];
    assign rom_addr   = look_quad[0] ? ~look_phase[PHASE_BITS-3 -: SINE_ADDR_BITS]
                                     :  look_phase[PHASE_BITS-3 -: SINE_ADDR_BITS];

    tofv_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS),
        .DATA_BITS (MAG_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (cmd.look),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.look)
            neg_reg <= look_quad[1];
    end

    // shared multiplier
    assign mul_a = cmd.mul_volume ? MUL_A_BITS'(volume_reg) : MUL_A_BITS'(mod_depth_reg);
    assign product_next = PROD_BITS'(mul_a) * PROD_BITS'(rom_data);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            product_reg <= product_next;
    end

    // deviation rounded half away from zero, then phase update
    assign dev_sum = (PROD_BITS + 1)'(product_reg) + ((PROD_BITS + 1)'(1) << (SAMPLE_BITS - 2));
    assign dev_mag = dev_sum[SAMPLE_BITS-1 +: PHASE_BITS];
    assign dev_add = neg_reg ? (~dev_mag + PHASE_BITS'(1)) : dev_mag;

    assign carrier_phase_next   = carrier_phase_reg + carrier_step_reg + dev_add;
    assign modulator_phase_next = modulator_phase_reg + modulator_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_phase_reg   <= '0;
            modulator_phase_reg <= '0;
        end
        else if (cmd.phase_update)
        begin
            carrier_phase_reg   <= carrier_phase_next;
            modulator_phase_reg <= modulator_phase_next;
        end
    end

    // output gain and output register
    assign vol_sum = (PROD_BITS + 1)'(product_reg) + ((PROD_BITS + 1)'(1) << (FRAC_BITS - 1));
    assign out_mag = vol_sum[FRAC_BITS +: SAMPLE_BITS];
    assign sample_out_next = neg_reg ? (~out_mag + SAMPLE_BITS'(1)) : out_mag;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            sample_out_reg <= sample_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

// File: hdl/two_operator_fm_voice.sv
`timescale 1ns / 1ps
// Two-operator FM voice: input channel in_valid/in_stall/sample_request,
// output channel out_valid/out_stall/sample_out (signed Q1.15).
// Configuration by single-cycle writes: cfg_write, cfg_index, cfg_data.
//   index 0 carrier_step, 1 modulator_step, 2 mod_depth, 3 volume (clamped to unity).
// A request with sample_request high starts one voice step; a request with
// sample_request low is taken and dropped.
// Per sample: modulator lookup and multiply, phase update, carrier lookup and
// multiply, output load; a new request is taken only after the output load. The
// sine ROM and the single shared multiplier are each used twice per sample, set by
// the controller sequence. in_stall is high while a sample is in progress.
// When the receiver stalls, the finished sample holds in the output register;
// the next request is still taken and runs up to the output load, where it waits.
// Reset clears both phases, the step registers and volume, sets mod_depth to
// 38044, and empties the output register. No clearing pass; ready at once.
// Depends on tofv_pkg, tofv_ctrl, tofv_datapath, tofv_sine_rom.
`include "two_operator_fm_voice_defines.svh"
module two_operator_fm_voice #(
    parameter int PHASE_BITS     = tofv_pkg::PHASE_BITS_DEFAULT,
    parameter int SINE_ADDR_BITS = tofv_pkg::SINE_ADDR_BITS_DEFAULT,
    parameter int SAMPLE_BITS    = tofv_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tofv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PHASE_BITS-1:0]               cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                sample_request,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    tofv_pkg::tofv_cmd_t    cmd;
    tofv_pkg::tofv_status_t status;

    tofv_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .sample_request (sample_request),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .status         (status)
    );

    tofv_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

    `TOFV_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall && sample_request, in_stall)
    `TOFV_ASSERT_SAME(a_load_into_free_slot, cmd.out_load, !out_valid || !out_stall)
    `TOFV_ASSERT_NEXT(a_load_shows_valid, cmd.out_load, out_valid)
    `TOFV_ASSERT_SAME(a_one_step_at_a_time, 1'b1,
                      $onehot0({cmd.look, cmd.mul, cmd.phase_update, cmd.out_load}))

endmodule

// File: tb/fm_sample_checker.sv
`timescale 1ns / 1ps
// Checker for two_operator_fm_voice: follows register writes, predicts each sample
// from its own phase accumulators and quarter-wave table, and compares results.
// Depends on tofv_pkg for the register indexes and reset constants.
module fm_sample_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tofv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [23:0]                         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                sample_request,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [15:0]                  sample_out,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int              ROM_AW      = 10;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint          SAMPLE_PEAK = 64'sd32767;

    int                 quarter_wave [0:(1 << ROM_AW) - 1];
    logic [23:0]        carrier_step;
    logic [23:0]        modulator_step;
    logic [22:0]        mod_depth;
    logic [15:0]        volume;
    logic [23:0]        carrier_phase;
    logic [23:0]        modulator_phase;
    logic signed [15:0] expected_samples [$];
    int                 errs;

    // Quarter-wave sine table, Taylor series in Q30 sampled at bin centers.
    initial
    begin : build_table
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int i = 0; i < (1 << ROM_AW); i++)
        begin
            x = (PI_HALF_Q30 * longint'(2 * i + 1)) >> (ROM_AW + 1);
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            v = (sum * SAMPLE_PEAK + (64'sd1 <<< 29)) >>> 30;
            if (v > SAMPLE_PEAK)
                v = SAMPLE_PEAK;
            quarter_wave[i] = int'(v);
        end
    end

    function automatic longint sine_at(input logic [23:0] ph);
        logic [ROM_AW-1:0] addr;
        addr = ph[21:12];
        if (ph[22])
            addr = ~addr;
        return ph[23] ? -longint'(quarter_wave[addr]) : longint'(quarter_wave[addr]);
    endfunction

    // gain * s / 2^15, rounded half away from zero
    function automatic longint scaled(input longint unsigned gain, input longint s);
        longint unsigned mag;
        longint unsigned r;
        mag = (s < 0) ? -s : s;
        r = (gain * mag + 64'd16384) >> 15;
        return (s < 0) ? -longint'(r) : longint'(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        longint             dev;
        longint             s;
        logic signed [15:0] want;
        if (!rst_n)
        begin
            carrier_step = '0;
            modulator_step = '0;
            mod_depth = 23'(tofv_pkg::MOD_DEPTH_RESET);
            volume = '0;
            carrier_phase = '0;
            modulator_phase = '0;
            expected_samples.delete();
            errs = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    tofv_pkg::CFG_CARRIER_STEP:   carrier_step = cfg_data;
                    tofv_pkg::CFG_MODULATOR_STEP: modulator_step = cfg_data;
                    tofv_pkg::CFG_MOD_DEPTH:      mod_depth = cfg_data[22:0];
                    tofv_pkg::CFG_VOLUME:
                        volume = (cfg_data[15:0] > tofv_pkg::VOLUME_UNITY) ?
                                 16'(tofv_pkg::VOLUME_UNITY) : cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    if (errs < 10)
                        $display("unexpected sample %0d with no request outstanding",
                                 sample_out);
                    errs++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        if (errs < 10)
                            $display("sample mismatch: expected %0d, got %0d",
                                     want, sample_out);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall && sample_request)
            begin
                dev = scaled(mod_depth, sine_at(modulator_phase));
                carrier_phase = carrier_phase + carrier_step + dev[23:0];
                modulator_phase = modulator_phase + modulator_step;
                s = scaled(volume, sine_at(carrier_phase));
                expected_samples.push_back(s[15:0]);
            end
            mismatches <= errs;
            outstanding <= expected_samples.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the two_operator_fm_voice testbench: clock, reset, register setup,
// sample requests and receiver stalls; the verdict comes from fm_sample_checker.
// Depends on tofv_pkg, two_operator_fm_voice and fm_sample_checker.
module tb_top;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [tofv_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [23:0]                         cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                sample_request = 1'b0;
    logic                                out_stall = 1'b0;
    logic                                in_stall;
    logic                                out_valid;
    logic signed [15:0]                  sample_out;
    int                                  mismatches;
    int                                  outstanding;
    int                                  cycle_count = 0;
    bit                                  calm = 1'b1;

    two_operator_fm_voice dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_request (sample_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample_out     (sample_out)
    );

    fm_sample_checker sample_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_request (sample_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample_out     (sample_out),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic write_reg(input logic [tofv_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [23:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic program_voice(input logic [23:0] cs, input logic [23:0] ms,
                                 input logic [23:0] md, input logic [23:0] vol);
        write_reg(tofv_pkg::CFG_CARRIER_STEP, cs);
        write_reg(tofv_pkg::CFG_MODULATOR_STEP, ms);
        write_reg(tofv_pkg::CFG_MOD_DEPTH, md);
        write_reg(tofv_pkg::CFG_VOLUME, vol);
    endtask

    task automatic send_item(input bit req);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample_request <= req;
        do @(posedge clk); while (in_stall);
    endtask

    // let every outstanding sample drain, then give the pipeline time to empty
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : receiver
        int hold;
        int r;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                hold = 0;
                out_stall <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    out_stall <= 1'b0;
                else if (r < 92)
                begin
                    hold = $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end
                else
                begin
                    hold = $urandom_range(15, 50);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        logic [23:0] cs;
        logic [23:0] ms;
        logic [23:0] md;
        logic [23:0] vol;
        int          n;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: silent output, carrier driven by the resting modulator
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        drain();

        calm = 1'b0;
        // half-turn steps, deepest modulation, volume above unity
        program_voice(24'h800000, 24'h800000, 24'h7FFFFF, 24'h00FFFF);
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        drain();

        program_voice(24'hFFFFFF, 24'd1, 24'd0, 24'(tofv_pkg::VOLUME_UNITY - 1));
        repeat (4) send_item(1'b1);
        drain();

        program_voice(24'd0, 24'h400000, 24'hFFFFFF, 24'(tofv_pkg::VOLUME_UNITY));
        repeat (6) send_item(1'b1);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            calm = (p % 4 == 3);
            case ($urandom_range(0, 5))
                0:       cs = 24'd0;
                1:       cs = 24'h800000;
                2:       cs = 24'($urandom_range(1, 64));
                3:       cs = 24'($urandom_range(0, 24'h800000));
                4:       cs = 24'($urandom);
                default: cs = 24'h800000 - 24'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       ms = 24'd0;
                1:       ms = 24'h800000;
                2:       ms = 24'($urandom_range(1, 64));
                3:       ms = 24'($urandom_range(0, 24'h800000));
                4:       ms = 24'($urandom);
                default: ms = 24'h800000 - 24'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 5))
                0:       md = 24'd0;
                1:       md = 24'h7FFFFF;
                2:       md = 24'(tofv_pkg::MOD_DEPTH_RESET);
                3:       md = 24'($urandom_range(0, 4095));
                4:       md = 24'($urandom);
                default: md = 24'($urandom_range(0, 24'h7FFFFF));
            endcase
            case ($urandom_range(0, 5))
                0:       vol = 24'd0;
                1:       vol = 24'(tofv_pkg::VOLUME_UNITY);
                2:       vol = 24'(tofv_pkg::VOLUME_UNITY - 1);
                3:       vol = 24'($urandom_range(0, tofv_pkg::VOLUME_UNITY));
                4:       vol = 24'($urandom);
                default: vol = 24'($urandom_range(tofv_pkg::VOLUME_UNITY + 1, 16'hFFFF));
            endcase
            program_voice(cs, ms, md, vol);
            n = $urandom_range(120, 180);
            repeat (n) send_item($urandom_range(0, 99) < 85);
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
